>>> rtl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash multimap package
// Field widths, action and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int ACTION_W  = 2;
   localparam int KEY_W     = 64;
   localparam int LEN_W     = 4;
   localparam int VALUE_W   = 24;
   localparam int STATUS_W  = 2;
   localparam int BIDX_O_W  = 7;
   localparam int COUNT_W   = 5;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [BIDX_O_W-1:0] bucket_out_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam action_type ACT_INSERT = 2'd0;
   localparam action_type ACT_SEARCH = 2'd1;
   localparam action_type ACT_DELETE = 2'd2;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EMPTY    = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_FILL_RD,
      S_DISPATCH,
      S_SEARCH_DATA,
      S_DELETE,
      S_OUT
   } state_type;

endpackage

>>> rtl/chained_hash_multimap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash multimap
// Hashes a short key into a bucket and inserts, lists or deletes bucket values.
// ----------------------------------------------------------------------------
// Usage: a request transaction carries an action, a key of up to eight bytes
// with its length, and a value. The key is hashed as the sum of its bytes
// modulo NUM_BUCKETS. Insert and delete give one response transaction; search
// gives one response per stored value, in order, with rsp_last on the final
// one, or a single empty response. Action code 3 is dropped without response.
// Sequencing: the hash remainder is found in two steps, a reciprocal
// multiplication for the quotient and a multiply-subtract for the remainder.
// A delete walks the bucket through the store memory at one entry per cycle
// and answers when the walk is done. A search reads the next stored value
// only once the current response has been taken. The next request is
// accepted after the last response of the current one has been taken.
// Reset: a clearing pass writes every bucket fill count to zero, one bucket
// per cycle, over all NUM_BUCKETS buckets; req_ready stays low until it is
// done. A stalled receiver holds the response register and the search walk
// waits with it.
// ----------------------------------------------------------------------------
module chained_hash_multimap #(
   parameter int NUM_BUCKETS  = 71,
   parameter int BUCKET_DEPTH = 16,
   parameter int KEY_BYTES    = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  chm_pkg::action_type      req_action,
   input  chm_pkg::key_type         req_key_bytes,
   input  chm_pkg::len_type         req_key_length,
   input  chm_pkg::value_type       req_item_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output chm_pkg::status_type      rsp_status,
   output chm_pkg::bucket_out_type  rsp_bucket_index,
   output chm_pkg::value_type       rsp_found_value,
   output chm_pkg::count_type       rsp_removed_count,
   output logic                     rsp_last
);

   localparam int BIDX_W      = $clog2(NUM_BUCKETS);
   localparam int SLOT_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
   localparam int SUM_W       = $clog2(KEY_BYTES * 255 + 1);
   localparam int NB_W        = $clog2(NUM_BUCKETS + 1);
   localparam int RECIP_SH    = SUM_W + NB_W;
   localparam int RECIP       = ((1 << RECIP_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS;
   localparam int RECIP_W     = SUM_W + 2;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int STORE_DEPTH = NUM_BUCKETS << SLOT_W;
   localparam int SADDR_W     = BIDX_W + SLOT_W;

   chm_pkg::state_type state_ff, state_in;
   chm_pkg::action_type action_ff, action_in;
   chm_pkg::value_type  value_ff, value_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quot_ff, quot_in;
   logic                step_ff, step_in;
   logic [BIDX_W-1:0]   bucket_ff, bucket_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [FILL_W-1:0]   kept_ff, kept_in;
   logic [BIDX_W-1:0]   clr_ff, clr_in;

   chm_pkg::status_type status_ff, status_in;
   chm_pkg::value_type  found_ff, found_in;
   chm_pkg::count_type  removed_ff, removed_in;
   logic                last_ff, last_in;

   logic [FILL_W-1:0]   fill_mem [NUM_BUCKETS];
   logic [FILL_W-1:0]   fill_rd_ff;
   logic                fill_we;
   logic [BIDX_W-1:0]   fill_waddr;
   logic [FILL_W-1:0]   fill_wdata;

   chm_pkg::value_type  store_mem [STORE_DEPTH];
   chm_pkg::value_type  store_rd_ff;
   logic                store_we;
   logic [SADDR_W-1:0]  store_waddr;
   logic [SADDR_W-1:0]  store_raddr;
   chm_pkg::value_type  store_wdata;

   chm_pkg::len_type    key_n;
   logic [SUM_W-1:0]    key_sum;
   logic [PROD_W-1:0]   recip_prod;
   logic [SUM_W-1:0]    quot_next;
   logic [SUM_W-1:0]    rem_value;

   // Byte sum of the key, limited to KEY_BYTES bytes.
   always_comb begin
      key_n = (req_key_length > chm_pkg::len_type'(KEY_BYTES)) ?
              chm_pkg::len_type'(KEY_BYTES) : req_key_length;
      key_sum = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (chm_pkg::len_type'(i) < key_n) begin
            key_sum = key_sum + SUM_W'(req_key_bytes[8*i +: 8]);
         end
      end
   end

   // The quotient by NUM_BUCKETS comes from a multiplication by its scaled
   // reciprocal; the remainder follows in the next cycle.
   always_comb begin
      recip_prod = PROD_W'(rem_ff) * PROD_W'(RECIP);
      quot_next  = SUM_W'(recip_prod >> RECIP_SH);
      rem_value  = rem_ff - SUM_W'(quot_ff * SUM_W'(NUM_BUCKETS));
   end

   assign req_ready = (state_ff == chm_pkg::S_IDLE);
   assign rsp_valid = (state_ff == chm_pkg::S_OUT);

   always_comb begin
      logic                keep;
      logic [FILL_W-1:0]   kept_next;
      logic                at_end;

      state_in    = state_ff;
      action_in   = action_ff;
      value_in    = value_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      step_in     = step_ff;
      bucket_in   = bucket_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      kept_in     = kept_ff;
      clr_in      = clr_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      removed_in  = removed_ff;
      last_in     = last_ff;

      fill_we     = 1'b0;
      fill_waddr  = bucket_ff;
      fill_wdata  = '0;
      store_we    = 1'b0;
      store_waddr = {bucket_ff, kept_ff[SLOT_W-1:0]};
      store_wdata = store_rd_ff;
      store_raddr = {bucket_ff, idx_ff};

      keep      = (store_rd_ff != value_ff);
      kept_next = kept_ff + FILL_W'(keep);
      at_end    = (FILL_W'(idx_ff) + FILL_W'(1) == fill_ff);

      unique case (state_ff)
         chm_pkg::S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + BIDX_W'(1);
            if (clr_ff == BIDX_W'(NUM_BUCKETS - 1)) begin
               state_in = chm_pkg::S_IDLE;
            end
         end
         chm_pkg::S_IDLE: begin
            if (req_valid && (req_action == chm_pkg::ACT_INSERT ||
                              req_action == chm_pkg::ACT_SEARCH ||
                              req_action == chm_pkg::ACT_DELETE)) begin
               action_in = req_action;
               value_in  = req_item_value;
               rem_in    = key_sum;
               step_in   = 1'b1;
               state_in  = chm_pkg::S_HASH;
            end
         end
         chm_pkg::S_HASH: begin
            if (step_ff) begin
               quot_in = quot_next;
               step_in = 1'b0;
            end else begin
               bucket_in = BIDX_W'(rem_value);
               state_in  = chm_pkg::S_FILL_RD;
            end
         end
         chm_pkg::S_FILL_RD: begin
            state_in = chm_pkg::S_DISPATCH;
         end
         chm_pkg::S_DISPATCH: begin
            fill_in     = fill_rd_ff;
            idx_in      = '0;
            kept_in     = '0;
            found_in    = '0;
            removed_in  = '0;
            last_in     = 1'b1;
            store_raddr = {bucket_ff, SLOT_W'(0)};
            state_in    = chm_pkg::S_OUT;
            unique case (action_ff)
               chm_pkg::ACT_INSERT: begin
                  if (fill_rd_ff == FILL_W'(BUCKET_DEPTH)) begin
                     status_in = chm_pkg::ST_FULL;
                  end else begin
                     store_we    = 1'b1;
                     store_waddr = {bucket_ff, fill_rd_ff[SLOT_W-1:0]};
                     store_wdata = value_ff;
                     fill_we     = 1'b1;
                     fill_wdata  = fill_rd_ff + FILL_W'(1);
                     status_in   = chm_pkg::ST_OK;
                  end
               end
               chm_pkg::ACT_SEARCH: begin
                  if (fill_rd_ff == '0) begin
                     status_in = chm_pkg::ST_EMPTY;
                  end else begin
                     state_in = chm_pkg::S_SEARCH_DATA;
                  end
               end
               default: begin
                  if (fill_rd_ff == '0) begin
                     status_in = chm_pkg::ST_NOTFOUND;
                  end else begin
                     state_in = chm_pkg::S_DELETE;
                  end
               end
            endcase
         end
         chm_pkg::S_SEARCH_DATA: begin
            status_in  = chm_pkg::ST_OK;
            found_in   = store_rd_ff;
            removed_in = '0;
            last_in    = at_end;
            state_in   = chm_pkg::S_OUT;
         end
         chm_pkg::S_DELETE: begin
            if (keep) begin
               store_we = 1'b1;
            end
            kept_in = kept_next;
            if (at_end) begin
               fill_we    = 1'b1;
               fill_wdata = kept_next;
               found_in   = '0;
               last_in    = 1'b1;
               if (kept_next == fill_ff) begin
                  status_in  = chm_pkg::ST_NOTFOUND;
                  removed_in = '0;
               end else begin
                  status_in  = chm_pkg::ST_OK;
                  removed_in = chm_pkg::count_type'(fill_ff - kept_next);
               end
               state_in = chm_pkg::S_OUT;
            end else begin
               idx_in      = idx_ff + SLOT_W'(1);
               store_raddr = {bucket_ff, idx_ff + SLOT_W'(1)};
            end
         end
         chm_pkg::S_OUT: begin
            if (rsp_ready) begin
               if (action_ff == chm_pkg::ACT_SEARCH && !last_ff) begin
                  idx_in      = idx_ff + SLOT_W'(1);
                  store_raddr = {bucket_ff, idx_ff + SLOT_W'(1)};
                  state_in    = chm_pkg::S_SEARCH_DATA;
               end else begin
                  state_in = chm_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = chm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chm_pkg::S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      value_ff   <= value_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      step_ff    <= step_in;
      bucket_ff  <= bucket_in;
      fill_ff    <= fill_in;
      idx_ff     <= idx_in;
      kept_ff    <= kept_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      removed_ff <= removed_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_rd_ff <= fill_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   assign rsp_status        = status_ff;
   assign rsp_bucket_index  = chm_pkg::bucket_out_type'(bucket_ff);
   assign rsp_found_value   = found_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_last          = last_ff;

endmodule
